[src/aett_pkg.sv]
`timescale 1ns / 1ps

package aett_pkg;

    // Default encoder resolution in bits (one turn = 2^RESOLUTION positions)
    localparam int RESOLUTION_DEF = 10;

    // Fixed field widths
    localparam int CODE_W   = 10;
    localparam int TURN_W   = 16;
    localparam int POS_W    = 27;
    localparam int DIR_W    = 2;

    // Input word operation selector
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_PRESET = 1'b1
    } op_t;

    // Direction of motion
    typedef enum logic [DIR_W-1:0] {
        DIR_STILL = 2'd0,
        DIR_CW    = 2'd1,
        DIR_CCW   = 2'd2
    } dir_t;

    // One result word
    typedef struct packed {
        logic               at_zero;
        logic signed [TURN_W-1:0] turns;
        dir_t               direction;
        logic signed [POS_W-1:0]  position;
    } result_t;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

endpackage

[src/aett_core.sv]
`timescale 1ns / 1ps

module aett_core #(
    parameter int RESOLUTION = aett_pkg::RESOLUTION_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  aett_pkg::op_t                     operation,
    input  logic [aett_pkg::CODE_W-1:0]       code,
    input  logic signed [aett_pkg::TURN_W-1:0] rotation_preset,
    input  logic                              multi_turn,
    output aett_pkg::result_t                 result
);

    localparam int FULL_W = (aett_pkg::TURN_W + RESOLUTION > aett_pkg::POS_W) ?
                            aett_pkg::TURN_W + RESOLUTION : aett_pkg::POS_W;
    localparam logic [RESOLUTION-1:0] QUARTER = RESOLUTION'(1) << (RESOLUTION - 2);

    logic [RESOLUTION-1:0]              last_raw_reg, last_raw_next;
    aett_pkg::dir_t                     last_dir_reg, last_dir_next;
    logic signed [aett_pkg::TURN_W-1:0] turn_count_reg, turn_count_next;

    logic [RESOLUTION-1:0] raw_in;
    logic [RESOLUTION-1:0] diff;
    logic                  raw_up;
    logic signed [FULL_W-1:0] pos_wide;

    // Work out the next tracking state for the offered word
    always_comb begin
        raw_in          = RESOLUTION'(code);
        raw_up          = raw_in > last_raw_reg;
        diff            = raw_up ? raw_in - last_raw_reg : last_raw_reg - raw_in;
        last_raw_next   = last_raw_reg;
        last_dir_next   = last_dir_reg;
        turn_count_next = turn_count_reg;
        if (operation == aett_pkg::OP_PRESET) begin
            turn_count_next = rotation_preset;
        end else if (raw_in != last_raw_reg) begin
            last_raw_next = raw_in;
            if (diff > QUARTER) begin
                // wrap through zero: count one turn in the last direction
                case (last_dir_reg)
                    aett_pkg::DIR_CW: begin
                        if (turn_count_reg != aett_pkg::TURN_MAX)
                            turn_count_next = turn_count_reg + 16'sd1;
                    end
                    aett_pkg::DIR_CCW: begin
                        if (turn_count_reg != aett_pkg::TURN_MIN)
                            turn_count_next = turn_count_reg - 16'sd1;
                    end
                    default: turn_count_next = turn_count_reg;
                endcase
            end else begin
                last_dir_next = raw_up ? aett_pkg::DIR_CW : aett_pkg::DIR_CCW;
            end
        end
    end

    // Build the result word from the updated state
    always_comb begin
        if (multi_turn)
            pos_wide = FULL_W'(signed'({turn_count_next, last_raw_next}));
        else
            pos_wide = FULL_W'({1'b0, last_raw_next});
        result.position  = pos_wide[aett_pkg::POS_W-1:0];
        result.direction = last_dir_next;
        result.turns     = turn_count_next;
        result.at_zero   = (last_raw_next == '0);
    end

    // Advance tracking state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg   <= '0;
            last_dir_reg   <= aett_pkg::DIR_STILL;
            turn_count_reg <= '0;
        end else if (accept) begin
            last_raw_reg   <= last_raw_next;
            last_dir_reg   <= last_dir_next;
            turn_count_reg <= turn_count_next;
        end
    end

    // A preset loads the turn count and leaves the position alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && operation == aett_pkg::OP_PRESET |=>
            turn_count_reg == $past(rotation_preset) && $stable(last_raw_reg))
        else $error("preset did not load turn count");

    // With no known direction a sample never moves the turn count
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && operation == aett_pkg::OP_SAMPLE && last_dir_reg == aett_pkg::DIR_STILL
            |=> $stable(turn_count_reg))
        else $error("turn count moved while still");

    // A repeated code changes nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && operation == aett_pkg::OP_SAMPLE && raw_in == last_raw_reg
            |=> $stable(last_dir_reg) && $stable(turn_count_reg))
        else $error("state changed on repeated code");

endmodule

[src/absolute_encoder_turn_tracker.sv]
`timescale 1ns / 1ps

// Absolute encoder turn tracker. Each input word either samples an encoder
// code or presets the turn count, and every accepted word yields exactly one
// result word in the next cycle: position, direction, saturating turn
// count and a zero flag. The tracking update is a single compare-and-add
// done as the word is taken, so the block accepts one word per clock unless
// the consumer stalls; the output register lets a new word in while the
// previous result waits, as long as the consumer takes it in the same cycle.
module absolute_encoder_turn_tracker #(
    parameter int RESOLUTION = aett_pkg::RESOLUTION_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: multi_turn
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] code, [25:10] rotation_preset, rest zero
    input  logic        s_tuser,   // operation
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [26:0] position, [28:27] direction,
                                   // [44:29] turns, [45] at_zero, rest zero
);

    logic              multi_turn_reg;
    logic              m_valid_reg;
    aett_pkg::result_t result;
    aett_pkg::result_t result_reg;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // Hold the multi-turn mode bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            multi_turn_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            multi_turn_reg <= cfg_data;
        end
    end

    aett_core #(
        .RESOLUTION (RESOLUTION)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .operation       (aett_pkg::op_t'(s_tuser)),
        .code            (s_tdata[9:0]),
        .rotation_preset (signed'(s_tdata[25:10])),
        .multi_turn      (multi_turn_reg),
        .result          (result)
    );

    // Output register: load on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule

[dv/absolute_encoder_turn_tracker_tb.sv]
`timescale 1ns / 1ps

module absolute_encoder_turn_tracker_tb;

    localparam int NPOS          = 1 << aett_pkg::RESOLUTION_DEF;
    localparam int QUARTER       = NPOS / 4;
    localparam int WORDS_PER_RUN = 180;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_GAP       = 60;
    localparam int MAX_REPORTS   = 200;

    // Turn-tracking predictor and store of expected result words
    class turn_scoreboard;
        aett_pkg::result_t expected_q[$];
        logic [aett_pkg::CODE_W-1:0]        last_raw;
        aett_pkg::dir_t                     last_dir;
        logic signed [aett_pkg::TURN_W-1:0] turn_cnt;
        bit                                 multi_turn;
        int errors;
        int words;
        int presets;
        int wraps;
        int results;

        function new();
            last_raw   = '0;
            last_dir   = aett_pkg::DIR_STILL;
            turn_cnt   = '0;
            multi_turn = 1'b0;
            errors     = 0;
            words      = 0;
            presets    = 0;
            wraps      = 0;
            results    = 0;
        endfunction

        function void set_mode(bit v);
            multi_turn = v;
        endfunction

        function int depth();
            return expected_q.size();
        endfunction

        // Advance the tracker by one input word and queue the result it gives
        function void note_word(logic [31:0] data, logic user);
            aett_pkg::op_t               op;
            logic [aett_pkg::CODE_W-1:0] raw;
            int                          diff;
            int                          pos;
            aett_pkg::result_t           exp_word;
            op  = aett_pkg::op_t'(user);
            raw = data[aett_pkg::CODE_W-1:0] & aett_pkg::CODE_W'(NPOS - 1);
            words++;
            if (op == aett_pkg::OP_PRESET) begin
                turn_cnt = data[aett_pkg::CODE_W +: aett_pkg::TURN_W];
                presets++;
            end else if (raw != last_raw) begin
                diff = (raw > last_raw) ? int'(raw) - int'(last_raw)
                                        : int'(last_raw) - int'(raw);
                if (diff > QUARTER) begin
                    // jump through zero: count one turn in the last direction
                    wraps++;
                    if (last_dir == aett_pkg::DIR_CW && turn_cnt != aett_pkg::TURN_MAX)
                        turn_cnt = turn_cnt + 16'sd1;
                    else if (last_dir == aett_pkg::DIR_CCW && turn_cnt != aett_pkg::TURN_MIN)
                        turn_cnt = turn_cnt - 16'sd1;
                end else begin
                    last_dir = (raw > last_raw) ? aett_pkg::DIR_CW : aett_pkg::DIR_CCW;
                end
                last_raw = raw;
            end
            pos = multi_turn ? int'(turn_cnt) * NPOS + int'(last_raw) : int'(last_raw);
            exp_word.position  = pos[aett_pkg::POS_W-1:0];
            exp_word.direction = last_dir;
            exp_word.turns     = turn_cnt;
            exp_word.at_zero   = (last_raw == '0);
            expected_q.push_back(exp_word);
        endfunction

        function void report(string field, longint exp_val, longint got_val);
            errors++;
            // limit log volume on a badly broken block
            if (errors <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", field, exp_val, got_val);
        endfunction

        // Compare one result word with the oldest expectation
        function void check_result(logic [47:0] data);
            aett_pkg::result_t got_word;
            aett_pkg::result_t exp_word;
            got_word = aett_pkg::result_t'(data[$bits(aett_pkg::result_t)-1:0]);
            results++;
            if (expected_q.size() == 0) begin
                errors++;
                $error("result word with nothing expected: position %0d", got_word.position);
                return;
            end
            exp_word = expected_q.pop_front();
            if (got_word.position !== exp_word.position)
                report("position", exp_word.position, got_word.position);
            if (got_word.direction !== exp_word.direction)
                report("direction", exp_word.direction, got_word.direction);
            if (got_word.turns !== exp_word.turns)
                report("turns", exp_word.turns, got_word.turns);
            if (got_word.at_zero !== exp_word.at_zero)
                report("at_zero", exp_word.at_zero, got_word.at_zero);
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [9:0] code, [25:10] rotation_preset
    logic        s_tuser   = 1'b0; // operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // [26:0] position, [28:27] direction,
                                   // [44:29] turns, [45] at_zero

    turn_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int walk_pos = 0;
    int walk_sign = 1;

    absolute_encoder_turn_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Monitor both channels, drive the receiver's stalls, watch for a hang
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one word after a random gap and hold it until taken
    task automatic send_word(aett_pkg::op_t op, logic [aett_pkg::CODE_W-1:0] code,
                             logic [aett_pkg::TURN_W-1:0] preset);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, preset, code};
        s_tuser  <= op;
        if (op == aett_pkg::OP_SAMPLE)
            walk_pos = int'(code);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and hold off until every expected word has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.depth() != 0)
            @(posedge aclk);
    endtask

    task automatic write_mode(bit v);
        drain();
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_mode(v);
    endtask

    // Mostly a rotating shaft with steady direction; some presets and noise
    task automatic random_word();
        int r;
        int step;
        logic [aett_pkg::TURN_W-1:0] pv;
        r = $urandom_range(99);
        if (r < 5) begin
            case ($urandom_range(5))
                0: pv = 16'h7FFF;
                1: pv = 16'h7FFE;
                2: pv = 16'h8000;
                3: pv = 16'h8001;
                4: pv = 16'h0000;
                default: pv = aett_pkg::TURN_W'($urandom);
            endcase
            send_word(aett_pkg::OP_PRESET, aett_pkg::CODE_W'($urandom), pv);
        end else if (r < 10) begin
            send_word(aett_pkg::OP_SAMPLE, aett_pkg::CODE_W'($urandom),
                      aett_pkg::TURN_W'($urandom));
        end else begin
            if ($urandom_range(99) < 8)
                walk_sign = -walk_sign;
            if (r < 18)
                step = QUARTER + $urandom_range(1);
            else if (r < 60)
                step = $urandom_range(QUARTER);
            else
                step = $urandom_range(8);
            // some backward jitter against the main direction
            if ($urandom_range(9) == 0)
                step = -step;
            step = step * walk_sign;
            send_word(aett_pkg::OP_SAMPLE,
                      aett_pkg::CODE_W'(((walk_pos + step) % NPOS + NPOS) % NPOS),
                      aett_pkg::TURN_W'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first-sample jump, quarter-turn edge, wraps, saturation
        write_mode(1'b1);
        send_word(aett_pkg::OP_SAMPLE, 10'h3FF, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'h3FF, 16'hFFFF);
        send_word(aett_pkg::OP_SAMPLE, 10'd767, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd768, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd0,   16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd1,   16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd1023, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd1022, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd0,   16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd257, 16'h0000);
        send_word(aett_pkg::OP_PRESET, 10'h3FF, 16'h7FFF);
        send_word(aett_pkg::OP_SAMPLE, 10'd300, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd1000, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd1023, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd0,   16'h0000);
        send_word(aett_pkg::OP_PRESET, 10'h2AA, 16'h8000);
        send_word(aett_pkg::OP_SAMPLE, 10'd100, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd50,  16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd1000, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd1023, 16'h0000);
        send_word(aett_pkg::OP_PRESET, 10'h155, 16'h5555);
        send_word(aett_pkg::OP_PRESET, 10'h000, 16'hFFFF);
        write_mode(1'b0);
        send_word(aett_pkg::OP_SAMPLE, 10'd700, 16'h0000);
        send_word(aett_pkg::OP_SAMPLE, 10'd0,   16'h0000);

        // Random phases over the stall patterns and both position modes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            write_mode(ph[0] ? 1'b1 : 1'b0);
            for (int i = 0; i < WORDS_PER_RUN; i++) begin
                random_word();
                if (i == WORDS_PER_RUN / 2)
                    drain();
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (sb.depth() != 0) begin
            sb.errors++;
            $error("%0d expected result words never arrived", sb.depth());
        end
        $display("covered %0d words (%0d presets, %0d wraps), %0d results checked",
                 sb.words, sb.presets, sb.wraps, sb.results);
        $display("four stall patterns, single- and multi-turn position modes");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
